/* hw/rtl/stok_pkg.sv */
// shared types, token kinds and keyword lookup for the source tokenizer
`default_nettype none
package stok_pkg;

    localparam logic [3:0] K_KEYWORD = 4'd0;
    localparam logic [3:0] K_IDENT   = 4'd1;
    localparam logic [3:0] K_INT     = 4'd2;
    localparam logic [3:0] K_FLOAT   = 4'd3;
    localparam logic [3:0] K_STRING  = 4'd4;
    localparam logic [3:0] K_OP      = 4'd5;
    localparam logic [3:0] K_DELIM   = 4'd6;
    localparam logic [3:0] K_END     = 4'd7;
    localparam logic [3:0] K_TOOBIG  = 4'd8;

    localparam logic [3:0] NOT_KW    = 4'd10;
    localparam logic [20:0] SAT21    = 21'h1FFFFF;
    localparam int NUM_KW            = 10;

    typedef struct packed {
        logic [3:0]  kind;
        logic [20:0] line;
        logic [19:0] start;
        logic [5:0]  len;
        logic [3:0]  kw;
        logic        last;
    } t_res;

    // first seven bytes of each keyword, first byte in the low bits
    function automatic logic [55:0] kw_word(input logic [3:0] k);
        logic [55:0] w;
        w = '0;
        unique case (k)
            4'd0:    w = 56'h746e69;
            4'd1:    w = 56'h74616f6c66;
            4'd2:    w = 56'h676e69727473;
            4'd3:    w = 56'h6669;
            4'd4:    w = 56'h65736c65;
            4'd5:    w = 56'h656c696877;
            4'd6:    w = 56'h726f66;
            4'd7:    w = 56'h6e7275746572;
            4'd8:    w = 56'h636e7566;
            4'd9:    w = 56'h746e697270;
            default: w = '1;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_lookup(input logic [55:0] pfx, input logic [5:0] len);
        logic [3:0] r;
        r = NOT_KW;
        if (len <= 6'd6) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if (kw_word(4'(k)) == pfx) r = 4'(k);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/source_tokenizer.sv */
// source tokenizer top level: input register, scanner, result queue
//
//  channel  | dir | tdata                         | tuser      | tlast
//  s_axis   | in  | source_byte[7:0]              | -          | end_of_source
//  m_axis   | out | line, start, length, keyword  | token_kind | last_of_run
//
// one byte is taken per cycle; each byte yields zero to three tokens
// the queue drains one token per cycle while m_axis_tready is high, so bytes yielding several tokens stall input
// reset (i_rst_n low, synchronous) returns to line 1, offset 0, empty queue
// a held byte waits in the input register until the queue has room for three words
`default_nettype none
module source_tokenizer import stok_pkg::*; #(
    parameter int MAX_TEXT   = 64,
    parameter int MAX_SOURCE = 1048576
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // source_byte
    input  wire         s_axis_tlast,   // end_of_source
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // line_number[20:0], start_offset[40:21], text_length[46:41], keyword_index[50:47]
    output logic [55:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last_of_run
);
    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_eos;
    logic       room, go;
    logic [1:0] cnt;
    t_res       res [3];
    t_res       head;

    assign go            = r_in_vld && room;
    assign s_axis_tready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_vld <= 1'b0;
        else if (s_axis_tready) r_in_vld <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
            r_eos  <= s_axis_tlast;
        end
    end

    stok_scan #(.MAX_TEXT(MAX_TEXT), .MAX_SOURCE(MAX_SOURCE)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_byte(r_byte), .i_eos(r_eos),
        .o_cnt(cnt), .o_res(res)
    );

    stok_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push_cnt(cnt), .i_push(res), .o_room(room),
        .o_valid(m_axis_tvalid), .o_head(head), .i_pop(m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, head.kw, head.len, head.start, head.line};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;
endmodule
`default_nettype wire

/* hw/rtl/stok_fifo.sv */
// small result queue: up to three words in, one word out per cycle while i_pop is high
`default_nettype none
module stok_fifo import stok_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire [1:0]  i_push_cnt,
    input  t_res       i_push [3],
    output logic       o_room,
    output logic       o_valid,
    output t_res       o_head,
    input  wire        i_pop
);
    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_pop;
    assign o_valid = r_cnt != 3'd0;
    assign o_head  = r_mem[r_rp];
    // three free slots needed, counting the word leaving this cycle
    assign o_room  = (r_cnt <= 3'd1) || (r_cnt == 3'd2 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push_cnt;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push_cnt} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < i_push_cnt) r_mem[r_wp + 2'(i)] <= i_push[i];
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/stok_scan.sv */
// scanner state and per-byte token recognition
`default_nettype none
module stok_scan import stok_pkg::*; #(
    parameter int MAX_TEXT   = 64,
    parameter int MAX_SOURCE = 1048576
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_go,
    input  wire [7:0]  i_byte,
    input  wire        i_eos,
    output logic [1:0] o_cnt,
    output t_res       o_res [3]
);
    localparam int PW  = $clog2(MAX_SOURCE) + 1;
    localparam int LIM = (MAX_TEXT - 1) < 63 ? (MAX_TEXT - 1) : 63;

    localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_INT = 4'd2, M_INTDOT = 4'd3,
        M_FLOAT = 4'd4, M_STRING = 4'd5, M_COMMENT = 4'd6, M_SLASH = 4'd7, M_EQ = 4'd8,
        M_BANG = 4'd9, M_LT = 4'd10, M_GT = 4'd11, M_DROP = 4'd12;

    logic [3:0]    r_mode, n_mode;
    logic [20:0]   r_line, n_line;
    logic [PW-1:0] r_pos, n_pos;
    logic [19:0]   r_start, n_start;
    logic [5:0]    r_len, n_len;
    logic [55:0]   r_pfx, n_pfx;
    logic          r_ovf, n_ovf;

    logic [1:0]  cnt;
    t_res        res [3];
    logic        done, dig, alpha;
    logic [24:0] pos1;
    logic [19:0] pos20;

    function automatic t_res mk(input logic [3:0] kind, input logic [20:0] line,
                                input logic [19:0] start, input logic [5:0] len,
                                input logic [3:0] kw);
        t_res r;
        r.kind  = kind;
        r.line  = line;
        r.start = start;
        r.len   = (len > 6'(LIM)) ? 6'(LIM) : len;
        r.kw    = kw;
        r.last  = 1'b0;
        return r;
    endfunction

    assign dig   = i_byte >= "0" && i_byte <= "9";
    assign alpha = (i_byte >= "A" && i_byte <= "Z") || (i_byte >= "a" && i_byte <= "z")
                   || i_byte == "_";
    assign pos1  = 25'(r_pos) + 25'd1;
    assign pos20 = pos1[19:0] - 20'd1;

    always_comb begin
        n_mode = r_mode; n_line = r_line; n_pos = r_pos; n_start = r_start;
        n_len = r_len; n_pfx = r_pfx; n_ovf = r_ovf;
        cnt = 2'd0;
        done = 1'b0;
        for (int i = 0; i < 3; i++) res[i] = mk(K_END, 21'd0, 20'd0, 6'd0, NOT_KW);

        if (r_ovf || r_pos >= PW'(MAX_SOURCE)) begin
            if (!r_ovf) begin
                n_ovf = 1'b1;
                n_mode = M_DROP;
                res[0] = mk(K_TOOBIG, r_line, 20'd0, 6'd0, NOT_KW);
                cnt = 2'd1;
            end
            if (i_eos) begin
                if (cnt == 2'd0) begin
                    res[0] = mk(K_TOOBIG, r_line, 20'd0, 6'd0, NOT_KW);
                    cnt = 2'd1;
                end
                n_mode = M_IDLE; n_line = 21'd1; n_pos = '0; n_start = '0;
                n_len = '0; n_pfx = '0; n_ovf = 1'b0;
            end
        end else begin
            // pending token against the new byte
            unique case (r_mode)
                M_IDENT: begin
                    if (alpha || dig) begin
                        if (n_len < 6'd7) n_pfx[{n_len[2:0], 3'b000} +: 8] = i_byte;
                        if (n_len != 6'd63) n_len = n_len + 6'd1;
                        done = 1'b1;
                    end else begin
                        res[cnt] = mk(kw_lookup(r_pfx, r_len) == NOT_KW ? K_IDENT : K_KEYWORD,
                                      n_line, r_start, r_len, kw_lookup(r_pfx, r_len));
                        cnt = cnt + 2'd1;
                    end
                end
                M_INT: begin
                    if (dig) begin
                        if (n_len != 6'd63) n_len = n_len + 6'd1;
                        done = 1'b1;
                    end else if (i_byte == ".") begin
                        n_mode = M_INTDOT;
                        done = 1'b1;
                    end else begin
                        res[cnt] = mk(K_INT, n_line, r_start, r_len, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                end
                M_INTDOT: begin
                    if (dig) begin
                        n_len = (r_len >= 6'd61) ? 6'd63 : r_len + 6'd2;
                        n_mode = M_FLOAT;
                        done = 1'b1;
                    end else begin
                        res[cnt] = mk(K_INT, n_line, r_start, r_len, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                end
                M_FLOAT: begin
                    if (dig) begin
                        if (n_len != 6'd63) n_len = n_len + 6'd1;
                        done = 1'b1;
                    end else begin
                        res[cnt] = mk(K_FLOAT, n_line, r_start, r_len, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                end
                M_STRING: begin
                    if (i_byte == "\"") begin
                        res[cnt] = mk(K_STRING, n_line, r_start, r_len, NOT_KW);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        if (i_byte == 8'h0a && n_line != SAT21) n_line = n_line + 21'd1;
                        if (n_len != 6'd63) n_len = n_len + 6'd1;
                    end
                    done = 1'b1;
                end
                M_COMMENT: begin
                    if (i_byte != 8'h0a) done = 1'b1;
                end
                M_SLASH: begin
                    if (i_byte == "/") begin
                        n_mode = M_COMMENT;
                        done = 1'b1;
                    end else begin
                        res[cnt] = mk(K_OP, n_line, r_start, 6'd1, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                end
                M_EQ, M_LT, M_GT, M_BANG: begin
                    if (i_byte == "=") begin
                        res[cnt] = mk(K_OP, n_line, r_start, 6'd2, NOT_KW);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                        done = 1'b1;
                    end else if (r_mode != M_BANG) begin
                        res[cnt] = mk(K_OP, n_line, r_start, 6'd1, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                end
                default: ;
            endcase

            // byte starts something new
            if (!done) begin
                n_mode = M_IDLE;
                if (i_byte == 8'h0a) begin
                    if (n_line != SAT21) n_line = n_line + 21'd1;
                end else if (i_byte == " " || i_byte == 8'h09 || i_byte == 8'h0d) begin
                end else if (i_byte == "\"") begin
                    n_mode = M_STRING; n_start = pos1[19:0]; n_len = '0; n_pfx = '0;
                end else if (dig) begin
                    n_mode = M_INT; n_start = pos20; n_len = 6'd1; n_pfx = '0;
                end else if (alpha) begin
                    n_mode = M_IDENT; n_start = pos20; n_len = 6'd1;
                    n_pfx = {48'd0, i_byte};
                end else begin
                    priority case (i_byte)
                        "/": begin n_mode = M_SLASH; n_start = pos20; n_len = '0; n_pfx = '0; end
                        "=": begin n_mode = M_EQ;    n_start = pos20; n_len = '0; n_pfx = '0; end
                        "!": begin n_mode = M_BANG;  n_start = pos20; n_len = '0; n_pfx = '0; end
                        "<": begin n_mode = M_LT;    n_start = pos20; n_len = '0; n_pfx = '0; end
                        ">": begin n_mode = M_GT;    n_start = pos20; n_len = '0; n_pfx = '0; end
                        "+", "-", "*": begin
                            res[cnt] = mk(K_OP, n_line, pos20, 6'd1, NOT_KW);
                            cnt = cnt + 2'd1;
                        end
                        "(", ")", "{", "}", ";", ",": begin
                            res[cnt] = mk(K_DELIM, n_line, pos20, 6'd1, NOT_KW);
                            cnt = cnt + 2'd1;
                        end
                        default: ;
                    endcase
                end
            end
            n_pos = pos1[PW-1:0];

            if (i_eos) begin
                unique case (n_mode)
                    M_IDENT: begin
                        res[cnt] = mk(kw_lookup(n_pfx, n_len) == NOT_KW ? K_IDENT : K_KEYWORD,
                                      n_line, n_start, n_len, kw_lookup(n_pfx, n_len));
                        cnt = cnt + 2'd1;
                    end
                    M_INT, M_INTDOT: begin
                        res[cnt] = mk(K_INT, n_line, n_start, n_len, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                    M_FLOAT: begin
                        res[cnt] = mk(K_FLOAT, n_line, n_start, n_len, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                    M_STRING: begin
                        res[cnt] = mk(K_STRING, n_line, n_start, n_len, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                    M_SLASH, M_EQ, M_LT, M_GT: begin
                        res[cnt] = mk(K_OP, n_line, n_start, 6'd1, NOT_KW);
                        cnt = cnt + 2'd1;
                    end
                    default: ;
                endcase
                // at most two results precede the end word
                res[cnt] = mk(K_END, n_line, pos1[19:0], 6'd0, NOT_KW);
                cnt = cnt + 2'd1;
                n_mode = M_IDLE; n_line = 21'd1; n_pos = '0; n_start = '0;
                n_len = '0; n_pfx = '0; n_ovf = 1'b0;
            end
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
    end

    assign o_cnt = i_go ? cnt : 2'd0;
    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= 21'd1; r_pos <= '0; r_start <= '0;
            r_len <= '0; r_pfx <= '0; r_ovf <= 1'b0;
        end else if (i_go) begin
            r_mode <= n_mode; r_line <= n_line; r_pos <= n_pos; r_start <= n_start;
            r_len <= n_len; r_pfx <= n_pfx; r_ovf <= n_ovf;
        end
    end
endmodule
`default_nettype wire
